FILE: sv/tv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tv_pkg;

  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int NORM_BITS = 30;
  localparam int MAG_W = 50;
  localparam int SUM_W = 62;
  localparam int ROOT_W = 31;
  localparam logic [14:0] OUT_MAG_MAX = 15'h7fff;

  typedef struct packed {
    logic [2:0]       neg;
    logic             degen;
    logic [2:0][29:0] mag;
  } tv_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tv_dside_t;

  function automatic logic [5:0] bit_len(input logic [MAG_W-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) r = 6'(i + 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tv_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module tv_isqrt import tv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SUM_W-1:0]  in_sum,
  input  wire tv_side_t          in_side,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root,
  output tv_side_t               out_side
);

  localparam int STEPS = SUM_W / 2 + 1;
  localparam int W = 64;

  logic [W-1:0] rem [STEPS+1];
  logic [W-1:0] res [STEPS+1];
  tv_side_t     side [STEPS+1];
  logic         vld [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 0; k < STEPS; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= W'(in_sum);
      res[0]  <= '0;
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - k));
    logic [W-1:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_root  = res[STEPS][ROOT_W-1:0];
  assign out_side  = side[STEPS];

endmodule
`default_nettype wire

FILE: sv/tv_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tv_div import tv_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [2:0][29:0]        in_mag,
  input  wire logic [ROOT_W-1:0]       in_len,
  input  wire tv_dside_t               in_side,
  output logic                         out_valid,
  output logic [2:0][OUT_FRAC_BITS:0]  out_q,
  output tv_dside_t                    out_side
);

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int NW = NORM_BITS + OUT_FRAC_BITS + 1;
  localparam int RW = ROOT_W + 1;

  logic [2:0][RW-1:0] rem  [QW+1];
  logic [2:0][QW-1:0] low  [QW+1];
  logic [2:0][QW-1:0] quo  [QW+1];
  logic [ROOT_W-1:0]  len  [QW+1];
  tv_dside_t          side [QW+1];
  logic               vld  [QW+1];

  logic [2:0][NW-1:0] num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NW'(in_mag[i]) << OUT_FRAC_BITS) + NW'(in_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 0; k < QW; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= RW'(num[i][NW-1:QW]);
        low[0][i] <= num[i][QW-1:0];
        quo[0][i] <= '0;
      end
      len[0]  <= in_len;
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [2:0][RW-1:0] cand;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cand[i] = {rem[k][i][RW-2:0], low[k][i][QW-1-k]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        len[k+1]  <= len[k];
        side[k+1] <= side[k];
        low[k+1]  <= low[k];
        for (int i = 0; i < 3; i++) begin
          if (cand[i] >= RW'(len[k])) begin
            rem[k+1][i] <= cand[i] - RW'(len[k]);
            quo[k+1][i] <= quo[k][i] | (QW'(1) << (QW - 1 - k));
          end else begin
            rem[k+1][i] <= cand[i];
            quo[k+1][i] <= quo[k][i];
          end
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_q     = quo[QW];
  assign out_side  = side[QW];

endmodule
`default_nettype wire

FILE: sv/triangle_tangent_vector.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  width  contents
// s_axis   in   384    pos1_x..pos3_z, uv1_pair..uv3_pair (32 bits each)
// m_axis   out  48+1   tangent_x/y/z in tdata, degenerate in tuser
//
// One triangle per cycle sustained while the skid register is empty.
// Pipeline: front stages, then square root (input register, then one result bit per stage),
// then quotient (input register, then one bit per stage), then result and output registers.
// The whole pipeline halts only when the output register and the skid
// register both hold a request; ready comes from a register.
// Synchronous reset clears all valid bits.
module triangle_tangent_vector import tv_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos1_x, pos1_y, pos1_z, pos2_x..pos3_z, uv1_pair, uv2_pair, uv3_pair
  input  wire logic [383:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tangent_x, tangent_y, tangent_z
  output logic [47:0]       m_axis_tdata,
  // degenerate
  output logic [0:0]        m_axis_tuser
);

  localparam int QW = OUT_FRAC_BITS + 1;

  logic en;
  logic [8:1] v;

  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic signed [16:0] du1, dv1, du2, dv2;
  logic signed [49:0] pa [3];
  logic signed [49:0] pb [3];
  logic signed [33:0] dp1, dp2;
  logic signed [50:0] t [3];
  logic detneg, detzero;
  logic [2:0] neg4, neg5, neg6, neg7, neg8;
  logic [MAG_W-1:0] mag4 [3];
  logic [MAG_W-1:0] mag5 [3];
  logic degen4, degen5, degen6, degen7, degen8;
  logic [5:0] blen;
  logic [2:0][29:0] smag6, smag7, smag8;
  logic [59:0] sq [3];
  logic [SUM_W-1:0] sum;

  logic signed [32:0] p [9];
  logic signed [16:0] uu [3];
  logic signed [16:0] vv [3];

  always_comb begin
    for (int i = 0; i < 9; i++) p[i] = 33'(signed'(s_axis_tdata[32*i +: 32]));
    for (int i = 0; i < 3; i++) begin
      uu[i] = 17'(signed'(s_axis_tdata[288 + 32*i + 16 +: 16]));
      vv[i] = 17'(signed'(s_axis_tdata[288 + 32*i +: 16]));
    end
  end

  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= p[3+i] - p[i];
        e2[i] <= p[6+i] - p[i];
      end
      du1 <= uu[1] - uu[0];
      dv1 <= vv[1] - vv[0];
      du2 <= uu[2] - uu[0];
      dv2 <= vv[2] - vv[0];

      for (int i = 0; i < 3; i++) begin
        pa[i] <= 50'(dv2 * e1[i]);
        pb[i] <= 50'(dv1 * e2[i]);
      end
      dp1 <= 34'(du1 * dv2);
      dp2 <= 34'(du2 * dv1);

      for (int i = 0; i < 3; i++) t[i] <= 51'(pa[i]) - 51'(pb[i]);
      detneg  <= dp1 < dp2;
      detzero <= dp1 == dp2;

      for (int i = 0; i < 3; i++) begin
        neg4[i] <= t[i][50] ^ detneg;
        mag4[i] <= t[i][50] ? MAG_W'(-t[i]) : MAG_W'(t[i]);
      end
      degen4 <= detzero;

      blen  <= bit_len(mag4[0] | mag4[1] | mag4[2]);
      degen5 <= degen4 || ((mag4[0] | mag4[1] | mag4[2]) == '0);
      neg5  <= neg4;
      for (int i = 0; i < 3; i++) mag5[i] <= mag4[i];

      for (int i = 0; i < 3; i++) begin
        if (blen > 6'(NORM_BITS)) smag6[i] <= 30'(mag5[i] >> (blen - 6'(NORM_BITS)));
        else smag6[i] <= 30'(mag5[i] << (6'(NORM_BITS) - blen));
      end
      neg6 <= neg5;
      degen6 <= degen5;

      for (int i = 0; i < 3; i++) sq[i] <= 60'(smag6[i]) * 60'(smag6[i]);
      smag7 <= smag6;
      neg7 <= neg6;
      degen7 <= degen6;

      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      smag8 <= smag7;
      neg8 <= neg7;
      degen8 <= degen7;
    end
  end

  tv_side_t isq_in_side, isq_out_side;
  logic isq_valid;
  logic [ROOT_W-1:0] root;

  assign isq_in_side = '{neg: neg8, degen: degen8, mag: smag8};

  tv_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v[8]), .in_sum(sum), .in_side(isq_in_side),
    .out_valid(isq_valid), .out_root(root), .out_side(isq_out_side)
  );

  tv_dside_t div_in_side, div_out_side;
  logic div_valid;
  logic [2:0][QW-1:0] quo;

  assign div_in_side = '{neg: isq_out_side.neg, degen: isq_out_side.degen};

  tv_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(isq_valid), .in_mag(isq_out_side.mag), .in_len(root),
    .in_side(div_in_side),
    .out_valid(div_valid), .out_q(quo), .out_side(div_out_side)
  );

  logic [2:0][15:0] comp;
  logic [31:0] q32 [3];
  logic [14:0] r15 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q32[i] = 32'(quo[i]);
      r15[i] = (q32[i] > 32'(OUT_MAG_MAX)) ? OUT_MAG_MAX : 15'(q32[i]);
      if (div_out_side.degen) comp[i] = '0;
      else if (div_out_side.neg[i]) comp[i] = -{1'b0, r15[i]};
      else comp[i] = {1'b0, r15[i]};
    end
  end

  logic fv;
  logic [47:0] fdata;
  logic fdeg;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fdata <= {comp[2], comp[1], comp[0]};
      fdeg  <= div_out_side.degen;
    end
  end

  logic ov, sv, take, arrive;
  logic [47:0] od, sd;
  logic odeg, sdeg;

  assign en     = !sv;
  assign take   = ov && m_axis_tready;
  assign arrive = en && fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (take) sv <= 1'b0;
    end else if (arrive) begin
      if (ov && !take) sv <= 1'b1;
      ov <= 1'b1;
    end else if (take) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (take) begin
        od   <= sd;
        odeg <= sdeg;
      end
    end else if (arrive) begin
      if (!ov || take) begin
        od   <= fdata;
        odeg <= fdeg;
      end else begin
        sd   <= fdata;
        sdeg <= fdeg;
      end
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = od;
  assign m_axis_tuser  = odeg;

  a_skid_order: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid holds a request while output is empty");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && odeg) |-> (od == '0))
    else $error("degenerate request with nonzero tangent");
  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (ov && !odeg) |-> (od != '0))
    else $error("regular request with zero tangent");
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tv_pkg::*;

  localparam int OFB = OUT_FRAC_BITS_DEF;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic        degen;
  } tangent_t;

  class tangent_scoreboard;
    tangent_t pending[$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function tangent_t tangent_of(logic [383:0] d);
      tangent_t r;
      longint p[9];
      longint u1, v1, u2, v2, u3, v3, du1, dv1, du2, dv2, det;
      longint t[3];
      longint unsigned mag[3], m, sum, len, q;
      bit neg[3];
      int b;
      for (int i = 0; i < 9; i++) p[i] = longint'($signed(d[32*i +: 32]));
      u1 = longint'($signed(d[32*9+16 +: 16]));  v1 = longint'($signed(d[32*9 +: 16]));
      u2 = longint'($signed(d[32*10+16 +: 16])); v2 = longint'($signed(d[32*10 +: 16]));
      u3 = longint'($signed(d[32*11+16 +: 16])); v3 = longint'($signed(d[32*11 +: 16]));
      du1 = u2 - u1; dv1 = v2 - v1;
      du2 = u3 - u1; dv2 = v3 - v1;
      det = du1 * dv2 - du2 * dv1;
      m = 0;
      for (int i = 0; i < 3; i++) begin
        t[i] = dv2 * (p[3+i] - p[i]) - dv1 * (p[6+i] - p[i]);
        if (det < 0) t[i] = -t[i];
        neg[i] = t[i] < 0;
        mag[i] = neg[i] ? longint'(-t[i]) : longint'(t[i]);
        if (mag[i] > m) m = mag[i];
      end
      r.tx = '0; r.ty = '0; r.tz = '0; r.degen = 1'b1;
      if (det == 0 || m == 0) return r;
      b = 0;
      for (int i = 0; i < 64; i++) if (m[i]) b = i + 1;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        if (b > NORM_BITS) mag[i] = mag[i] >> (b - NORM_BITS);
        else mag[i] = mag[i] << (NORM_BITS - b);
        sum += mag[i] * mag[i];
      end
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << OFB) + (len >> 1)) / len;
        if (q > 32767) q = 32767;
        mag[i] = neg[i] ? -q : q;
      end
      r.tx = mag[0][15:0]; r.ty = mag[1][15:0]; r.tz = mag[2][15:0];
      r.degen = 1'b0;
      return r;
    endfunction

    function void note(logic [383:0] d);
      pending.push_back(tangent_of(d));
    endfunction

    task check(logic [47:0] d, logic deg);
      tangent_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h/%b", d, deg));
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.tx) report($sformatf("x got %h exp %h", d[15:0], e.tx));
      if (d[31:16] !== e.ty) report($sformatf("y got %h exp %h", d[31:16], e.ty));
      if (d[47:32] !== e.tz) report($sformatf("z got %h exp %h", d[47:32], e.tz));
      if (deg !== e.degen) report($sformatf("degenerate got %b exp %b", deg, e.degen));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [383:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [47:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  tangent_scoreboard sb = new();
  int cycle = 0;

  always #5 clk = ~clk;

  triangle_tangent_vector DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] uvp(logic [15:0] u, logic [15:0] v);
    return {u, v};
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      4: return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  task automatic send_tri(logic [31:0] w[12]);
    int g;
    @(negedge clk);
    for (int i = 0; i < 12; i++) s_axis_tdata[32*i +: 32] = w[i];
    s_axis_tvalid = 1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note(s_axis_tdata);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      s_axis_tvalid = 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic random_tri();
    logic [31:0] w[12];
    int k;
    logic [31:0] base;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) w[i] = $urandom();
    if (k >= 2 && k <= 6) begin
      for (int i = 0; i < 9; i++) w[i] = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      for (int i = 9; i < 12; i++)
        w[i] = uvp(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)));
    end else if (k == 7) begin
      w[10] = w[9];
    end else if (k == 8) begin
      base = $urandom();
      for (int i = 0; i < 9; i += 3) begin
        w[i] = base; w[i+1] = base ^ 32'h1; w[i+2] = ~base;
      end
    end else if (k == 9) begin
      for (int i = 0; i < 12; i++) w[i] = edge_word();
    end
    send_tri(w);
  endtask

  task automatic directed();
    logic [31:0] w[12];
    for (int n = 0; n < 20; n++) begin
      for (int i = 0; i < 12; i++) w[i] = '0;
      case (n)
        0: ;
        1: begin
          w[3] = 32'h0001_0000; w[7] = 32'h0001_0000;
          w[10] = uvp(16'h1000, 16'h0); w[11] = uvp(16'h0, 16'h1000);
        end
        2: begin
          for (int i = 0; i < 3; i++) begin
            w[i] = 32'h8000_0000; w[3+i] = 32'h7fff_ffff; w[6+i] = 32'h8000_0000;
          end
          w[9] = uvp(16'h8000, 16'h8000); w[10] = uvp(16'h7fff, 16'h8000);
          w[11] = uvp(16'h8000, 16'h7fff);
        end
        3: begin
          for (int i = 0; i < 9; i++) w[i] = (i % 2) ? 32'h7fff_ffff : 32'h8000_0000;
          w[9] = uvp(16'h7fff, 16'h7fff); w[10] = uvp(16'h8000, 16'h7fff);
          w[11] = uvp(16'h7fff, 16'h8000);
        end
        4: begin
          w[3] = 32'h0001_0000; w[7] = 32'h0001_0000;
          w[10] = uvp(16'h1000, 16'h1000); w[11] = uvp(16'h2000, 16'h2000);
        end
        5: begin
          w[10] = uvp(16'h1000, 16'h0); w[11] = uvp(16'h0, 16'h1000);
        end
        6: begin
          w[3] = 32'h0000_0001; w[10] = uvp(16'h0001, 16'h0);
          w[11] = uvp(16'h0, 16'hffff);
        end
        7: begin
          w[3] = 32'hffff_ffff; w[4] = 32'hffff_ffff; w[5] = 32'hffff_ffff;
          w[10] = uvp(16'h0, 16'h0001); w[11] = uvp(16'h0001, 16'h0);
        end
        8: begin
          w[0] = 32'h7fff_ffff; w[3] = 32'h8000_0000; w[7] = 32'h0000_0001;
          w[9] = uvp(16'h7fff, 16'h7fff); w[10] = uvp(16'h8000, 16'h8000);
          w[11] = uvp(16'h8000, 16'h7fff);
        end
        9: begin
          w[3] = 32'h0003_0000; w[4] = 32'h0004_0000;
          w[10] = uvp(16'h0, 16'h0800); w[11] = uvp(16'h0800, 16'h0);
        end
        default: for (int i = 0; i < 12; i++) w[i] = edge_word();
      endcase
      send_tri(w);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    directed();
    for (int n = 0; n < 1150; n++) random_tri();
    @(negedge clk);
    s_axis_tvalid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!rst && cycle > 3000 && cycle < 3400) begin
        m_axis_tready = 0;
      end else if (hold > 0) begin
        m_axis_tready = 0;
        hold--;
      end else begin
        m_axis_tready = 1;
        if ($urandom_range(0, 99) < 25) begin
          m_axis_tready = 0;
          hold = gap_len();
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser[0]);
    if (cycle > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

FILE: filelist.f
sv/tv_pkg.sv
sv/tv_isqrt.sv
sv/tv_div.sv
sv/triangle_tangent_vector.sv
verif/tb_top.sv
